// ----- rtl/core/lpg_pkg.sv -----
// Shared constants and types of the line pixel generator.
package lpg_pkg;

   localparam int COORD_BITS_DEFAULT = 8;
   localparam int COLOR_BITS = 16;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic line_active;
      logic major_dir_neg;
      logic minor_dir_neg;
      logic y_is_major;
   } lpg_ctrl_type;

endpackage

// ----- rtl/core/lpg_if.sv -----
// Valid/ready channel interfaces for the request and response words.
interface lpg_req_if #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
);
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [COORD_BITS-1:0]              start_x;
   logic [COORD_BITS-1:0]              start_y;
   logic [COORD_BITS-1:0]              end_x;
   logic [COORD_BITS-1:0]              end_y;
   logic [lpg_pkg::COLOR_BITS-1:0]     line_color;

   modport source (output valid, kind, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink (input valid, kind, start_x, start_y, end_x, end_y, line_color,
                 output ready);
endinterface

interface lpg_rsp_if #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
);
   logic                               valid;
   logic                               ready;
   logic                               pixel_valid;
   logic [COORD_BITS-1:0]              pixel_x;
   logic [COORD_BITS-1:0]              pixel_y;
   logic [lpg_pkg::COLOR_BITS-1:0]     pixel_rgb;
   logic                               last_pixel;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_rgb, last_pixel,
                   input ready);
   modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_rgb, last_pixel,
                 output ready);
endinterface

// ----- rtl/core/line_pixel_generator.sv -----
// Top level of the line pixel generator.
//
// Requests arrive as words on req_port. A load word (kind low) sets up a new line from
// its start point, end point and colour and returns nothing; it replaces any line that
// is still being drawn. A tick word (kind high) returns exactly one word on rsp_port:
// the next pixel of the active line, or a word with pixel_valid low when no line is
// active. The end point is not drawn, so a line whose start equals its end yields no
// pixels. last_pixel marks the final pixel, after which the line is no longer active.
// Each word is handled by the combinational step logic; the response appears in the
// output register in the cycle after the tick is accepted. One word is accepted in every
// cycle, set by the single response register: the block takes a new word whenever that
// register is empty or is being read in the same cycle, so it stalls only while a
// response waits and the receiver holds ready low.
// Synchronous reset clears the active-line flag and empties the response register.
module line_pixel_generator #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   lpg_req_if.sink   req_port,
   lpg_rsp_if.source rsp_port
);
   import lpg_pkg::*;

   localparam int ERR_BITS = COORD_BITS + 2;

   lpg_ctrl_type                 ctrl_ff, ctrl_in;
   logic [COORD_BITS-1:0]        major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]        minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0]        major_stop_ff, major_stop_in;
   logic [COORD_BITS-1:0]        major_delta_ff, major_delta_in;
   logic [COORD_BITS-1:0]        minor_delta_ff, minor_delta_in;
   logic signed [ERR_BITS-1:0]   error_acc_ff, error_acc_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         pixel_valid_ff, pixel_valid_in;
   logic [COORD_BITS-1:0]        pixel_x_ff, pixel_x_in;
   logic [COORD_BITS-1:0]        pixel_y_ff, pixel_y_in;
   logic [COLOR_BITS-1:0]        pixel_rgb_ff, pixel_rgb_in;
   logic                         last_pixel_ff, last_pixel_in;

   logic                         req_ready;
   logic                         req_accept;
   logic                         load_accept;
   logic                         tick_accept;
   logic                         flip_x, flip_y;
   logic [COORD_BITS-1:0]        delta_x, delta_y;

   logic [COORD_BITS-1:0]        step_x, step_y;
   logic                         step_last;
   logic [COORD_BITS-1:0]        step_major_pos, step_minor_pos;
   logic signed [ERR_BITS-1:0]   step_error_acc;

   assign req_ready = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = req_ready;
   assign req_accept = req_port.valid && req_ready;
   assign load_accept = req_accept && (req_port.kind == KIND_LOAD);
   assign tick_accept = req_accept && (req_port.kind == KIND_TICK);

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.pixel_valid = pixel_valid_ff;
   assign rsp_port.pixel_x = pixel_x_ff;
   assign rsp_port.pixel_y = pixel_y_ff;
   assign rsp_port.pixel_rgb = pixel_rgb_ff;
   assign rsp_port.last_pixel = last_pixel_ff;

   lpg_step #(
      .COORD_BITS(COORD_BITS)
   ) u_step (
      .ctrl           (ctrl_ff),
      .major_pos      (major_pos_ff),
      .minor_pos      (minor_pos_ff),
      .major_stop     (major_stop_ff),
      .major_delta    (major_delta_ff),
      .minor_delta    (minor_delta_ff),
      .error_acc      (error_acc_ff),
      .pixel_x        (step_x),
      .pixel_y        (step_y),
      .last_pixel     (step_last),
      .next_major_pos (step_major_pos),
      .next_minor_pos (step_minor_pos),
      .next_error_acc (step_error_acc)
   );

   always_comb begin
      flip_x = req_port.end_x < req_port.start_x;
      flip_y = req_port.end_y < req_port.start_y;
      delta_x = flip_x ? req_port.start_x - req_port.end_x : req_port.end_x - req_port.start_x;
      delta_y = flip_y ? req_port.start_y - req_port.end_y : req_port.end_y - req_port.start_y;

      ctrl_in = ctrl_ff;
      major_pos_in = major_pos_ff;
      minor_pos_in = minor_pos_ff;
      major_stop_in = major_stop_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      error_acc_in = error_acc_ff;
      color_in = color_ff;

      if (load_accept) begin
         if (delta_y <= delta_x) begin
            ctrl_in.y_is_major = 1'b0;
            major_pos_in = req_port.start_x;
            major_stop_in = req_port.end_x;
            minor_pos_in = req_port.start_y;
            major_delta_in = delta_x;
            minor_delta_in = delta_y;
            ctrl_in.major_dir_neg = flip_x;
            ctrl_in.minor_dir_neg = flip_y;
         end else begin
            ctrl_in.y_is_major = 1'b1;
            major_pos_in = req_port.start_y;
            major_stop_in = req_port.end_y;
            minor_pos_in = req_port.start_x;
            major_delta_in = delta_y;
            minor_delta_in = delta_x;
            ctrl_in.major_dir_neg = flip_y;
            ctrl_in.minor_dir_neg = flip_x;
         end
         color_in = req_port.line_color;
         error_acc_in = '0;
         ctrl_in.line_active = (delta_x != '0) || (delta_y != '0);
      end else if (tick_accept && ctrl_ff.line_active) begin
         major_pos_in = step_major_pos;
         minor_pos_in = step_minor_pos;
         error_acc_in = step_error_acc;
         ctrl_in.line_active = !step_last;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      pixel_valid_in = pixel_valid_ff;
      pixel_x_in = pixel_x_ff;
      pixel_y_in = pixel_y_ff;
      pixel_rgb_in = pixel_rgb_ff;
      last_pixel_in = last_pixel_ff;
      if (tick_accept) begin
         rsp_valid_in = 1'b1;
         if (ctrl_ff.line_active) begin
            pixel_valid_in = 1'b1;
            pixel_x_in = step_x;
            pixel_y_in = step_y;
            pixel_rgb_in = color_ff;
            last_pixel_in = step_last;
         end else begin
            pixel_valid_in = 1'b0;
            pixel_x_in = '0;
            pixel_y_in = '0;
            pixel_rgb_in = '0;
            last_pixel_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_ff <= ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff <= major_pos_in;
      minor_pos_ff <= minor_pos_in;
      major_stop_ff <= major_stop_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      error_acc_ff <= error_acc_in;
      color_ff <= color_in;
      pixel_valid_ff <= pixel_valid_in;
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      pixel_rgb_ff <= pixel_rgb_in;
      last_pixel_ff <= last_pixel_in;
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(tick_accept))
      else $error("Response appeared without an accepted tick.");

   assert property (@(posedge clock) disable iff (reset)
      tick_accept && ctrl_ff.line_active && step_last |=> !ctrl_ff.line_active)
      else $error("Line still active after its final pixel.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_pixel_ff |-> pixel_valid_ff)
      else $error("Final-pixel flag on a word without a pixel.");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("Request stalled while the response register is empty.");
`endif

endmodule

// ----- rtl/core/lpg_step.sv -----
// One rasteriser step: current pixel and the advanced line state.
module lpg_step #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
   input  lpg_pkg::lpg_ctrl_type          ctrl,
   input  logic [COORD_BITS-1:0]          major_pos,
   input  logic [COORD_BITS-1:0]          minor_pos,
   input  logic [COORD_BITS-1:0]          major_stop,
   input  logic [COORD_BITS-1:0]          major_delta,
   input  logic [COORD_BITS-1:0]          minor_delta,
   input  logic signed [COORD_BITS+1:0]   error_acc,
   output logic [COORD_BITS-1:0]          pixel_x,
   output logic [COORD_BITS-1:0]          pixel_y,
   output logic                           last_pixel,
   output logic [COORD_BITS-1:0]          next_major_pos,
   output logic [COORD_BITS-1:0]          next_minor_pos,
   output logic signed [COORD_BITS+1:0]   next_error_acc
);
   import lpg_pkg::*;

   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int EXT_BITS = COORD_BITS + 4;

   logic signed [EXT_BITS-1:0] err_sum;
   logic signed [EXT_BITS-1:0] err_twice;
   logic signed [EXT_BITS-1:0] major_ext;
   logic signed [EXT_BITS-1:0] err_after;
   logic                       minor_step;

   always_comb begin
      pixel_x = ctrl.y_is_major ? minor_pos : major_pos;
      pixel_y = ctrl.y_is_major ? major_pos : minor_pos;

      major_ext = $signed({{(EXT_BITS-COORD_BITS){1'b0}}, major_delta});
      err_sum = $signed({{(EXT_BITS-ERR_BITS){error_acc[ERR_BITS-1]}}, error_acc})
              + $signed({{(EXT_BITS-COORD_BITS){1'b0}}, minor_delta});
      err_twice = err_sum <<< 1;
      minor_step = err_twice >= major_ext;
      err_after = minor_step ? err_sum - major_ext : err_sum;
      next_error_acc = err_after[ERR_BITS-1:0];

      if (minor_step) begin
         next_minor_pos = ctrl.minor_dir_neg ? minor_pos - 1'b1 : minor_pos + 1'b1;
      end else begin
         next_minor_pos = minor_pos;
      end
      next_major_pos = ctrl.major_dir_neg ? major_pos - 1'b1 : major_pos + 1'b1;
      last_pixel = next_major_pos == major_stop;
   end

endmodule
